// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// shared concurrent assertion macros, sampled on clk_i, disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold in the same cycle
`define NTOA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define NTOA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ntoa_pkg.sv =====
// ----------------------------------------------------------------------------
// ntoa_pkg
// shared widths, op codes, ascii codes and the job record of the formatter
// ----------------------------------------------------------------------------
`default_nettype none

package ntoa_pkg;

  localparam int unsigned DEC_DIGITS_DEF = 8;
  localparam int unsigned VALUE_W        = 28;
  localparam int unsigned MAG_W          = 28;
  localparam int unsigned CHAR_W         = 7;
  localparam int unsigned IDX_W          = 4;   // covers digit positions up to ten digits
  localparam int unsigned WIDE_W         = 36;  // holds 9 * 10^9

  localparam logic [1:0] OP_DEC = 2'd0;
  localparam logic [1:0] OP_BIN = 2'd1;
  localparam logic [1:0] OP_HEX = 2'd2;

  localparam logic [CHAR_W-1:0] CH_ZERO      = 7'h30;
  localparam logic [CHAR_W-1:0] CH_ONE       = 7'h31;
  localparam logic [CHAR_W-1:0] CH_MINUS     = 7'h2D;
  localparam logic [CHAR_W-1:0] CH_HEX_ALPHA = 7'h37;

  typedef struct packed {
    logic              active;
    logic [1:0]        op;
    logic              neg;
    logic [MAG_W-1:0]  mag;
    logic [IDX_W-1:0]  idx;
    logic [7:0]        low_byte;
  } job_t;

  // d * 10^k, evaluated on constant arguments only
  function automatic logic [WIDE_W-1:0] pow10_mul(input int unsigned k, input int unsigned d);
    logic [WIDE_W-1:0] r;
    r = WIDE_W'(d);
    for (int unsigned i = 0; i < k; i++) begin
      r = r * WIDE_W'(10);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/ntoa_prep.sv =====
// ----------------------------------------------------------------------------
// ntoa_prep
// turns a registered item into a job: sign, saturated magnitude, start index
// ----------------------------------------------------------------------------
`default_nettype none

module ntoa_prep import ntoa_pkg::*; #(
  parameter int unsigned DEC_DIGITS = DEC_DIGITS_DEF
) (
  input  logic [1:0]         op_i,
  input  logic [VALUE_W-1:0] value_i,
  output job_t               job_o
);

  logic              neg;
  logic [MAG_W-1:0]  mag_raw;
  logic [MAG_W-1:0]  mag_sat;
  logic [WIDE_W-1:0] limit;
  logic [IDX_W-1:0]  dec_idx;

  assign neg     = value_i[VALUE_W-1];
  assign mag_raw = neg ? (MAG_W'(0) - MAG_W'(value_i)) : MAG_W'(value_i);
  assign limit   = pow10_mul(DEC_DIGITS, 1) - WIDE_W'(1);

  always_comb begin
    if (WIDE_W'(mag_raw) > limit) begin
      mag_sat = limit[MAG_W-1:0];
    end else begin
      mag_sat = mag_raw;
    end
  end

  // position of the leading digit, zero prints as one digit
  always_comb begin
    dec_idx = '0;
    for (int unsigned j = 1; j < DEC_DIGITS; j++) begin
      if (WIDE_W'(mag_sat) >= pow10_mul(j, 1)) begin
        dec_idx = IDX_W'(j);
      end
    end
  end

  always_comb begin
    job_o          = '0;
    job_o.op       = op_i;
    job_o.neg      = 1'b0;
    job_o.mag      = mag_sat;
    job_o.low_byte = value_i[7:0];
    unique case (op_i)
      OP_DEC: begin
        job_o.active = 1'b1;
        job_o.neg    = neg;
        job_o.idx    = dec_idx;
      end
      OP_BIN: begin
        job_o.active = 1'b1;
        job_o.idx    = IDX_W'(7);
      end
      OP_HEX: begin
        job_o.active = 1'b1;
        job_o.idx    = IDX_W'(1);
      end
      default: begin
        job_o.active = 1'b0;
        job_o.idx    = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/ntoa_ser.sv =====
// ----------------------------------------------------------------------------
// ntoa_ser
// holds one job and produces one character of it per enabled cycle
// ----------------------------------------------------------------------------
`default_nettype none

module ntoa_ser import ntoa_pkg::*; #(
  parameter int unsigned DEC_DIGITS = DEC_DIGITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  job_t              job_i,
  input  logic              load_valid_i,
  output logic              load_ready_o,
  input  logic              emit_en_i,
  output logic              char_valid_o,
  output logic [CHAR_W-1:0] char_o,
  output logic              last_o
);

  logic              busy_q;
  logic [1:0]        op_q;
  logic              neg_q, neg_d;
  logic [MAG_W-1:0]  rem_q, rem_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [7:0]        low_byte_q;

  logic [WIDE_W-1:0] mult [1:9];
  logic [3:0]        digit;
  logic [WIDE_W-1:0] sub;
  logic [3:0]        nib;
  logic [CHAR_W-1:0] step_char;
  logic              step_last;
  logic              emit;
  logic              load;

  // one decimal digit: parallel compares against the multiples of 10^idx
  always_comb begin
    for (int unsigned d = 1; d <= 9; d++) begin
      mult[d] = '0;
    end
    for (int unsigned j = 0; j < DEC_DIGITS; j++) begin
      if (idx_q == IDX_W'(j)) begin
        for (int unsigned d = 1; d <= 9; d++) begin
          mult[d] = pow10_mul(j, d);
        end
      end
    end
    digit = '0;
    for (int unsigned d = 1; d <= 9; d++) begin
      if (WIDE_W'(rem_q) >= mult[d]) begin
        digit = 4'(d);
      end
    end
    sub = '0;
    for (int unsigned d = 1; d <= 9; d++) begin
      if (digit == 4'(d)) begin
        sub = mult[d];
      end
    end
  end

  assign nib = idx_q[0] ? low_byte_q[7:4] : low_byte_q[3:0];

  always_comb begin
    step_char = CH_ZERO;
    step_last = (idx_q == '0);
    neg_d     = neg_q;
    rem_d     = rem_q;
    idx_d     = idx_q - IDX_W'(1);
    case (op_q)
      OP_DEC: begin
        if (neg_q) begin
          step_char = CH_MINUS;
          step_last = 1'b0;
          neg_d     = 1'b0;
          idx_d     = idx_q;
        end else begin
          step_char = CH_ZERO + CHAR_W'(digit);
          rem_d     = rem_q - sub[MAG_W-1:0];
        end
      end
      OP_BIN: begin
        step_char = low_byte_q[idx_q[2:0]] ? CH_ONE : CH_ZERO;
      end
      OP_HEX: begin
        step_char = (nib < 4'd10) ? (CH_ZERO + CHAR_W'(nib)) : (CH_HEX_ALPHA + CHAR_W'(nib));
      end
      default: begin
        step_last = 1'b1;
      end
    endcase
  end

  assign emit         = busy_q && emit_en_i;
  assign load_ready_o = !busy_q || (emit_en_i && step_last);
  assign load         = load_valid_i && load_ready_o;

  assign char_valid_o = emit;
  assign char_o       = step_char;
  assign last_o       = step_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (load) begin
      busy_q <= job_i.active;
    end else if (emit && step_last) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      op_q       <= job_i.op;
      neg_q      <= job_i.neg;
      rem_q      <= job_i.mag;
      idx_q      <= job_i.idx;
      low_byte_q <= job_i.low_byte;
    end else if (emit) begin
      neg_q <= neg_d;
      rem_q <= rem_d;
      idx_q <= idx_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/number_to_ascii_formatter_top.sv =====
// ----------------------------------------------------------------------------
// number_to_ascii_formatter_top
// formats a value as signed decimal, binary or hex ascii, one character per item
// ----------------------------------------------------------------------------
//  channel | signals                          | direction
//  in      | in_valid_i, in_stall_o, op_i,    | item in
//          | value_i                          |
//  out     | out_valid_o, out_stall_i,        | one character item out
//          | character_o, last_o              |
//
//  one character leaves per cycle while out_stall_i is low and an item is in work;
//  an input item gives 1 to DEC_DIGITS+1 characters decimal, 8 binary, 2 hex
//  an unused op code is taken by the serializer and produces nothing
//  the first character passes input register, serializer and output register
//  the input register takes the next item while the serializer is busy
//  reset clears all valid flags, no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module number_to_ascii_formatter_top import ntoa_pkg::*; #(
  parameter int unsigned DEC_DIGITS = DEC_DIGITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         op_i,
  input  logic [VALUE_W-1:0] value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [CHAR_W-1:0]  character_o,
  output logic               last_o
);

  logic               in_valid_q;
  logic [1:0]         op_q;
  logic [VALUE_W-1:0] value_q;

  logic               out_valid_q;
  logic [CHAR_W-1:0]  character_q;
  logic               last_q;

  job_t               job;
  logic               ser_ready;
  logic               emit_en;
  logic               ser_valid;
  logic [CHAR_W-1:0]  ser_char;
  logic               ser_last;
  logic               in_take;

  assign in_stall_o = in_valid_q && !ser_ready;
  assign in_take    = in_valid_i && !in_stall_o;
  assign emit_en    = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q    <= op_i;
      value_q <= value_i;
    end
  end

  ntoa_prep #(
    .DEC_DIGITS(DEC_DIGITS)
  ) u_prep (
    .op_i   (op_q),
    .value_i(value_q),
    .job_o  (job)
  );

  ntoa_ser #(
    .DEC_DIGITS(DEC_DIGITS)
  ) u_ser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job),
    .load_valid_i(in_valid_q),
    .load_ready_o(ser_ready),
    .emit_en_i   (emit_en),
    .char_valid_o(ser_valid),
    .char_o      (ser_char),
    .last_o      (ser_last)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_en) begin
      out_valid_q <= ser_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ser_valid) begin
      character_q <= ser_char;
      last_q      <= ser_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign character_o = character_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

// ===== src/ntoa_checker.sv =====
// ----------------------------------------------------------------------------
// ntoa_checker
// port level checks of the formatter, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ntoa_checker import ntoa_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic [1:0]         op_i,
  input logic [VALUE_W-1:0] value_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [CHAR_W-1:0]  character_o,
  input logic               last_o
);

  logic minus_out;
  logic char_ok;

  assign minus_out = out_valid_o && (character_o == CH_MINUS);
  assign char_ok   = ((character_o >= 7'h30) && (character_o <= 7'h39)) ||
                     ((character_o >= 7'h41) && (character_o <= 7'h46)) ||
                     (character_o == CH_MINUS);

  // a stalled item holds
  `NTOA_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(character_o) && $stable(last_o), "stalled output item changed")

  // only digits, hex letters and minus leave the block
  `NTOA_ASSERT(a_char_set, !out_valid_o || char_ok, "character outside the output set")

  // a minus sign is never the last character of an item
  `NTOA_ASSERT(a_minus_not_last, !minus_out || !last_o, "minus sign marked as last")

endmodule

bind number_to_ascii_formatter_top ntoa_checker u_checker (.*);

`default_nettype wire

// ===== tb/tb_number_to_ascii_formatter_top.sv =====
// ----------------------------------------------------------------------------
// tb_number_to_ascii_formatter_top
// self-checking bench: a table of directed numbers, then three random phases,
// the first two with sender and receiver stalls; every character item is checked
// in order against the table text or an in-bench formatter that expands the number
// ----------------------------------------------------------------------------
`default_nettype none

module tb_number_to_ascii_formatter_top import ntoa_pkg::*;;

  localparam logic [1:0] OP_NONE     = 2'd3;
  localparam int         CYCLE_LIMIT = 200000;
  localparam int         DRAIN_WAIT  = 24;
  localparam int         RAND_ITEMS  = 67;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } char_item_t;

  typedef struct {
    logic [1:0]         op;
    logic [VALUE_W-1:0] value;
    bit                 typed;
    string              text;
  } number_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         op_i = OP_DEC;
  logic [VALUE_W-1:0] value_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [CHAR_W-1:0]  character_o;
  logic               last_o;

  char_item_t pending_chars[$];
  int         err_count = 0;
  int         cycle_count = 0;
  int         tx_idle_pct = 0;
  int         rx_idle_pct = 0;

  number_row_t number_table[] = '{
    '{OP_DEC,  28'd0,             1'b1, "0"},
    '{OP_DEC,  28'd1,             1'b1, "1"},
    '{OP_DEC,  28'hFFFFFFF,       1'b1, "-1"},
    '{OP_DEC,  28'd99999999,      1'b1, "99999999"},
    '{OP_DEC,  28'(-99999999),    1'b1, "-99999999"},
    '{OP_DEC,  28'd100000000,     1'b1, "99999999"},
    '{OP_DEC,  28'h7FFFFFF,       1'b1, "99999999"},
    '{OP_DEC,  28'h8000000,       1'b1, "-99999999"},
    '{OP_DEC,  28'd10000000,      1'b1, "10000000"},
    '{OP_DEC,  28'd9,             1'b0, ""},
    '{OP_DEC,  28'd10,            1'b0, ""},
    '{OP_DEC,  28'(-1234567),     1'b0, ""},
    '{OP_BIN,  28'd0,             1'b1, "00000000"},
    '{OP_BIN,  28'h00000FF,       1'b1, "11111111"},
    '{OP_BIN,  28'hFFFFFFF,       1'b1, "11111111"},
    '{OP_BIN,  28'h5555500,       1'b1, "00000000"},
    '{OP_BIN,  28'h00000A5,       1'b0, ""},
    '{OP_HEX,  28'd0,             1'b1, "00"},
    '{OP_HEX,  28'h00000FF,       1'b1, "FF"},
    '{OP_HEX,  28'hFFFFFFF,       1'b1, "FF"},
    '{OP_HEX,  28'h000009A,       1'b0, ""},
    '{OP_HEX,  28'hABCDE3C,       1'b0, ""},
    '{OP_NONE, 28'd0,             1'b1, ""},
    '{OP_NONE, 28'hFFFFFFF,       1'b1, ""}
  };

  number_to_ascii_formatter_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .character_o (character_o),
    .last_o      (last_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  task automatic note_error(input string msg);
    err_count++;
    if (err_count <= 10) begin
      $display("error at %0t: %s", $time, msg);
    end
  endtask

  function automatic void queue_chars(input logic [CHAR_W-1:0] chars[$]);
    char_item_t item;
    foreach (chars[i]) begin
      item.ch   = chars[i];
      item.last = (i == chars.size() - 1);
      pending_chars.push_back(item);
    end
  endfunction

  function automatic void expect_text(input string text);
    logic [CHAR_W-1:0] chars[$];
    byte               code;
    for (int i = 0; i < text.len(); i++) begin
      code = text[i];
      chars.push_back(code[CHAR_W-1:0]);
    end
    queue_chars(chars);
  endfunction

  // expands one number into the characters it formats to
  function automatic void expect_format(input logic [1:0] op, input logic [VALUE_W-1:0] value);
    logic [CHAR_W-1:0] chars[$];
    int                sval;
    longint            mag;
    longint            top;
    longint            p;
    logic [3:0]        nib;
    top = 1;
    for (int i = 1; i < DEC_DIGITS_DEF; i++) begin
      top = top * 10;
    end
    case (op)
      OP_DEC: begin
        sval = $signed(value);
        mag  = (sval < 0) ? -longint'(sval) : longint'(sval);
        if (mag > top * 10 - 1) begin
          mag = top * 10 - 1;
        end
        if (mag == 0) begin
          chars.push_back(CH_ZERO);
        end else begin
          if (sval < 0) begin
            chars.push_back(CH_MINUS);
          end
          for (p = top; p > 0; p = p / 10) begin
            if (p <= mag) begin
              chars.push_back(CH_ZERO + CHAR_W'((mag / p) % 10));
            end
          end
        end
      end
      OP_BIN: begin
        for (int i = 7; i >= 0; i--) begin
          chars.push_back(value[i] ? CH_ONE : CH_ZERO);
        end
      end
      OP_HEX: begin
        for (int i = 1; i >= 0; i--) begin
          nib = value[4*i +: 4];
          chars.push_back((nib < 4'd10) ? CH_ZERO + CHAR_W'(nib) : CH_HEX_ALPHA + CHAR_W'(nib));
        end
      end
      default: begin
      end
    endcase
    queue_chars(chars);
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    longint v;
    int     k;
    case ($urandom_range(0, 4))
      0: v = $urandom;
      1: v = longint'($urandom_range(0, 400)) - 200;
      2: v = longint'($urandom_range(0, 199999998)) - 99999999;
      3: v = 99999998 + longint'($urandom_range(0, 3));
      default: begin
        k = $urandom_range(0, 8);
        v = 1;
        for (int i = 0; i < k; i++) begin
          v = v * 10;
        end
        v = v - longint'($urandom_range(0, 1));
      end
    endcase
    if ($urandom_range(0, 1)) begin
      v = -v;
    end
    return VALUE_W'(v);
  endfunction

  // holds valid low for a random number of cycles
  task automatic idle_sender();
    int gap;
    gap = 0;
    while (gap < 16 && $urandom_range(0, 99) < tx_idle_pct) begin
      gap++;
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_number(input logic [1:0] op, input logic [VALUE_W-1:0] value,
                             input bit typed, input string text);
    idle_sender();
    in_valid_i <= 1'b1;
    op_i       <= op;
    value_i    <= value;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (typed) begin
      expect_text(text);
    end else begin
      expect_format(op, value);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < rx_idle_pct);
  end

  // character checker
  always @(posedge clk_i) begin
    char_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_chars.size() == 0) begin
        note_error($sformatf("unexpected character %h last %b", character_o, last_o));
      end else begin
        want = pending_chars.pop_front();
        if (character_o !== want.ch) begin
          note_error($sformatf("character expected %h got %h", want.ch, character_o));
        end
        if (last_o !== want.last) begin
          note_error($sformatf("last expected %b got %b", want.last, last_o));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_pct = 33;
    rx_idle_pct = 49;
    foreach (number_table[i]) begin
      send_number(number_table[i].op, number_table[i].value,
                  number_table[i].typed, number_table[i].text);
    end
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 49 : 0;
      rx_idle_pct = (phase == 0) ? 49 : (phase == 1) ? 33 : 0;
      for (int n = 0; n < RAND_ITEMS; n++) begin
        send_number(($urandom_range(0, 15) == 0) ? OP_NONE : 2'($urandom_range(0, 2)),
                    pick_value(), 1'b0, "");
      end
      wait_drained();
    end

    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+src
src/ntoa_pkg.sv
src/ntoa_prep.sv
src/ntoa_ser.sv
src/number_to_ascii_formatter_top.sv
src/ntoa_checker.sv
tb/tb_number_to_ascii_formatter_top.sv
